/* src/bitmap_text_glyph_blitter_defines.svh */
// assertion macros shared by the checker
`ifndef BITMAP_TEXT_GLYPH_BLITTER_DEFINES_SVH
`define BITMAP_TEXT_GLYPH_BLITTER_DEFINES_SVH

// same-cycle implication, ignored while reset is high
`define BTGB_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// next-cycle implication, ignored while reset is high
`define BTGB_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

/* src/btgb_pkg.sv */
package btgb_pkg;

  // field widths
  localparam int COORD_W    = 16;
  localparam int COLOR_W    = 32;
  localparam int ADDR_W     = 32;
  localparam int CODE_W     = 8;
  localparam int FIDX_W     = 12;
  localparam int FBYTE_W    = 8;
  localparam int DIM_W      = 13;
  localparam int STRIDE_W   = 14;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int MASK_W     = 8;

  // font layout: every glyph owns 16 byte slots
  localparam int ROW_FIELD_W = 4;
  localparam int GLYPH_W     = 8;
  localparam int LINE_STEP   = 16;

  localparam logic [COORD_W-1:0] COORD_MAX = 16'hFFFF;

  // control characters
  localparam logic [CODE_W-1:0] CHAR_NUL = 8'h00;
  localparam logic [CODE_W-1:0] CHAR_LF  = 8'h0A;
  localparam logic [CODE_W-1:0] CHAR_CR  = 8'h0D;

  // register reset values
  localparam logic [DIM_W-1:0]    RST_FRAME_WIDTH  = 13'd640;
  localparam logic [DIM_W-1:0]    RST_FRAME_HEIGHT = 13'd480;
  localparam logic [STRIDE_W-1:0] RST_ROW_STRIDE   = 14'd640;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_BASE   = 2'd0,
    REG_FRAME_WIDTH  = 2'd1,
    REG_FRAME_HEIGHT = 2'd2,
    REG_ROW_STRIDE   = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_ADDR,
    ST_ROWS
  } blit_state_t;

  // controller to datapath
  typedef struct packed {
    logic in_ready;
    logic take;
    logic setup;
    logic addr_init;
    logic row_load;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic draw_go;
    logic out_free;
    logic last;
  } dp_status_t;

endpackage

/* src/btgb_ifs.sv */
// character / font load channel
interface btgb_in_if;
  logic                               valid;
  logic                               ready;
  logic                               cmd;
  logic                               new_string;
  logic [btgb_pkg::COORD_W-1:0]       origin_x;
  logic [btgb_pkg::COORD_W-1:0]       origin_y;
  logic [btgb_pkg::CODE_W-1:0]        char_code;
  logic [btgb_pkg::COLOR_W-1:0]       draw_color;
  logic [btgb_pkg::FIDX_W-1:0]        font_index;
  logic [btgb_pkg::FBYTE_W-1:0]       font_byte;

  modport source (output valid, cmd, new_string, origin_x, origin_y, char_code,
                  draw_color, font_index, font_byte, input ready);
  modport sink (input valid, cmd, new_string, origin_x, origin_y, char_code,
                draw_color, font_index, font_byte, output ready);
  modport monitor (input valid, ready, cmd, new_string, origin_x, origin_y,
                   char_code, draw_color, font_index, font_byte);
endinterface

// framebuffer row write channel
interface btgb_out_if;
  logic                         valid;
  logic                         ready;
  logic [btgb_pkg::ADDR_W-1:0]  row_address;
  logic [btgb_pkg::MASK_W-1:0]  pixel_mask;
  logic [btgb_pkg::COLOR_W-1:0] pixel_color;
  logic                         last_row;

  modport source (output valid, row_address, pixel_mask, pixel_color, last_row,
                  input ready);
  modport sink (input valid, row_address, pixel_mask, pixel_color, last_row,
                output ready);
  modport monitor (input valid, ready, row_address, pixel_mask, pixel_color,
                   last_row);
endinterface

// register write channel
interface btgb_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [btgb_pkg::CFG_IDX_W-1:0]  index;
  logic [btgb_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
  modport monitor (input valid, ready, index, data);
endinterface

/* src/btgb_ctrl.sv */
module btgb_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  btgb_pkg::dp_status_t sts,
  output btgb_pkg::dp_cmd_t    cmd
);

  btgb_pkg::blit_state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= btgb_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      btgb_pkg::ST_IDLE: begin
        cmd.in_ready = 1'b1;
        cmd.take     = in_valid;
        if (in_valid && sts.draw_go) begin
          state_next = btgb_pkg::ST_SETUP;
        end
      end
      btgb_pkg::ST_SETUP: begin
        cmd.setup  = 1'b1;
        state_next = btgb_pkg::ST_ADDR;
      end
      btgb_pkg::ST_ADDR: begin
        cmd.addr_init = 1'b1;
        state_next    = btgb_pkg::ST_ROWS;
      end
      btgb_pkg::ST_ROWS: begin
        if (sts.out_free) begin
          cmd.row_load = 1'b1;
          if (sts.last) begin
            state_next = btgb_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_next = btgb_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* src/btgb_dpath.sv */
module btgb_dpath #(
  parameter int FONT_GLYPHS = 256,
  parameter int GLYPH_ROWS  = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  // command and status
  input  btgb_pkg::dp_cmd_t                   cmd,
  output btgb_pkg::dp_status_t                sts,
  // register writes
  input  logic                                cfg_we,
  input  logic [btgb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [btgb_pkg::CFG_DATA_W-1:0]     cfg_data,
  // input payload
  input  logic                                in_cmd,
  input  logic                                new_string,
  input  logic [btgb_pkg::COORD_W-1:0]        origin_x,
  input  logic [btgb_pkg::COORD_W-1:0]        origin_y,
  input  logic [btgb_pkg::CODE_W-1:0]         char_code,
  input  logic [btgb_pkg::COLOR_W-1:0]        draw_color,
  input  logic [btgb_pkg::FIDX_W-1:0]         font_index,
  input  logic [btgb_pkg::FBYTE_W-1:0]        font_byte,
  // output register
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic [btgb_pkg::ADDR_W-1:0]         row_address,
  output logic [btgb_pkg::MASK_W-1:0]         pixel_mask,
  output logic [btgb_pkg::COLOR_W-1:0]        pixel_color,
  output logic                                last_row
);

  localparam int GW         = $clog2(FONT_GLYPHS);
  localparam int AW         = GW + btgb_pkg::ROW_FIELD_W;
  localparam int FONT_BYTES = FONT_GLYPHS * (2 ** btgb_pkg::ROW_FIELD_W);
  localparam int RW         = $clog2(GLYPH_ROWS);
  localparam int PROD_W     = btgb_pkg::COORD_W + btgb_pkg::STRIDE_W;

  function automatic logic [btgb_pkg::COORD_W-1:0] sat_add(
    input logic [btgb_pkg::COORD_W-1:0] a,
    input logic [btgb_pkg::COORD_W-1:0] b
  );
    logic [btgb_pkg::COORD_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[btgb_pkg::COORD_W] ? btgb_pkg::COORD_MAX : s[btgb_pkg::COORD_W-1:0];
  endfunction

  // configuration registers
  logic [btgb_pkg::ADDR_W-1:0]   frame_base;
  logic [btgb_pkg::DIM_W-1:0]    frame_width;
  logic [btgb_pkg::DIM_W-1:0]    frame_height;
  logic [btgb_pkg::STRIDE_W-1:0] row_stride;

  // text cursor state
  logic [btgb_pkg::COORD_W-1:0] cursor_x, cursor_x_next;
  logic [btgb_pkg::COORD_W-1:0] cursor_y, cursor_y_next;
  logic [btgb_pkg::COORD_W-1:0] line_x, line_x_next;
  logic                         stopped, stopped_next;

  // glyph being drawn
  logic [btgb_pkg::COORD_W-1:0] g_x;
  logic [btgb_pkg::COORD_W-1:0] g_y;
  logic [GW-1:0]                g_code;
  logic                         g_blank;
  logic [btgb_pkg::COLOR_W-1:0] g_color;
  logic [btgb_pkg::MASK_W-1:0]  clip;
  logic [RW-1:0]                rows_m1;
  logic [PROD_W-1:0]            prod;
  logic [btgb_pkg::ADDR_W-1:0]  cur_addr;
  logic [RW-1:0]                row;

  // font memory
  logic [btgb_pkg::FBYTE_W-1:0] font_mem [FONT_BYTES];
  logic [btgb_pkg::FBYTE_W-1:0] rd_data;
  logic                         rd_en;
  logic [RW-1:0]                rd_row;
  logic [AW-1:0]                rd_addr;
  logic                         load_we;

  logic [btgb_pkg::COORD_W-1:0] eff_x, eff_y, eff_ls;
  logic                         eff_run, printable, in_frame;
  logic [btgb_pkg::DIM_W-1:0]   cols_diff, rows_diff;
  logic                         draw_take;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_base   <= '0;
      frame_width  <= btgb_pkg::RST_FRAME_WIDTH;
      frame_height <= btgb_pkg::RST_FRAME_HEIGHT;
      row_stride   <= btgb_pkg::RST_ROW_STRIDE;
    end else if (cfg_we) begin
      case (btgb_pkg::cfg_reg_t'(cfg_index))
        btgb_pkg::REG_FRAME_BASE:   frame_base   <= cfg_data;
        btgb_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg_data[btgb_pkg::DIM_W-1:0];
        btgb_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data[btgb_pkg::DIM_W-1:0];
        btgb_pkg::REG_ROW_STRIDE:   row_stride   <= cfg_data[btgb_pkg::STRIDE_W-1:0];
        default: ;
      endcase
    end
  end

  // cursor as seen after a possible string start
  assign eff_x   = new_string ? origin_x : cursor_x;
  assign eff_y   = new_string ? origin_y : cursor_y;
  assign eff_ls  = new_string ? origin_x : line_x;
  assign eff_run = new_string || !stopped;

  assign printable = (char_code != btgb_pkg::CHAR_NUL) && (char_code != btgb_pkg::CHAR_CR)
                     && (char_code != btgb_pkg::CHAR_LF);
  assign in_frame  = (frame_width >= btgb_pkg::DIM_W'(btgb_pkg::GLYPH_W))
                     && ({3'b000, frame_width} > eff_x)
                     && ({3'b000, frame_height} > eff_y);

  assign sts.draw_go = in_cmd && eff_run && printable && in_frame;
  assign draw_take   = cmd.take && in_cmd;

  // cursor update per character
  always_comb begin
    cursor_x_next = eff_x;
    cursor_y_next = eff_y;
    line_x_next   = eff_ls;
    stopped_next  = new_string ? 1'b0 : stopped;
    if (eff_run) begin
      case (char_code)
        btgb_pkg::CHAR_NUL: stopped_next = 1'b1;
        btgb_pkg::CHAR_CR:  cursor_x_next = eff_ls;
        btgb_pkg::CHAR_LF: begin
          cursor_x_next = eff_ls;
          cursor_y_next = sat_add(eff_y, btgb_pkg::COORD_W'(btgb_pkg::LINE_STEP));
        end
        default: cursor_x_next = sat_add(eff_x, btgb_pkg::COORD_W'(btgb_pkg::GLYPH_W));
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_x <= '0;
      cursor_y <= '0;
      line_x   <= '0;
      stopped  <= 1'b1;
    end else if (draw_take) begin
      cursor_x <= cursor_x_next;
      cursor_y <= cursor_y_next;
      line_x   <= line_x_next;
      stopped  <= stopped_next;
    end
  end

  // capture glyph parameters
  always_ff @(posedge clk) begin
    if (draw_take) begin
      g_x     <= eff_x;
      g_y     <= eff_y;
      g_code  <= char_code[GW-1:0];
      g_blank <= {1'b0, char_code} >= 9'(FONT_GLYPHS);
      g_color <= draw_color;
    end
  end

  // clip window and row count, limited to the part of the glyph inside the frame
  assign cols_diff = frame_width - g_x[btgb_pkg::DIM_W-1:0];
  assign rows_diff = frame_height - g_y[btgb_pkg::DIM_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      clip    <= (cols_diff >= btgb_pkg::DIM_W'(btgb_pkg::GLYPH_W)) ? '1
                 : ~(8'hFF >> cols_diff[2:0]);
      rows_m1 <= (rows_diff >= btgb_pkg::DIM_W'(GLYPH_ROWS)) ? RW'(GLYPH_ROWS - 1)
                 : RW'(rows_diff - 1'b1);
      prod    <= g_y * row_stride;
    end
  end

  // row address walk
  always_ff @(posedge clk) begin
    if (cmd.addr_init) begin
      cur_addr <= frame_base + btgb_pkg::ADDR_W'(g_x) + btgb_pkg::ADDR_W'(prod);
      row      <= '0;
    end else if (cmd.row_load) begin
      cur_addr <= cur_addr + btgb_pkg::ADDR_W'(row_stride);
      row      <= row + 1'b1;
    end
  end

  // font memory, row of the next write is fetched ahead, on address init or the previous row load
  assign load_we = cmd.take && !in_cmd && ({1'b0, font_index} < 13'(FONT_BYTES));
  assign rd_en   = cmd.addr_init || cmd.row_load;
  assign rd_row  = cmd.addr_init ? '0 : row + 1'b1;
  assign rd_addr = {g_code, btgb_pkg::ROW_FIELD_W'(rd_row)};

  always_ff @(posedge clk) begin
    if (load_we) begin
      font_mem[font_index[AW-1:0]] <= font_byte;
    end
    if (rd_en) begin
      rd_data <= font_mem[rd_addr];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.row_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.row_load) begin
      row_address <= cur_addr;
      pixel_mask  <= g_blank ? '0 : (rd_data & clip);
      pixel_color <= g_color;
      last_row    <= (row == rows_m1);
    end
  end

  assign sts.out_free = !out_valid || out_ready;
  assign sts.last     = (row == rows_m1);

endmodule

/* src/bitmap_text_glyph_blitter.sv */
// a font load or a control character is taken in the idle state; a drawn glyph
// passes through the setup and address states, then loads its rows into the
// output register; it holds the input until its last row (up to GLYPH_ROWS rows)
// is loaded, each font row is read ahead, and row loads are paced by the output stall
// reset: cursor and line start clear to 0, the string is stopped, registers take
// their defaults; font memory is not cleared and has no clearing pass
module bitmap_text_glyph_blitter #(
  parameter int FONT_GLYPHS = 256,
  parameter int GLYPH_ROWS  = 16
) (
  input logic        clk,
  input logic        rst,
  btgb_in_if.sink    in_ch,
  btgb_out_if.source out_ch,
  btgb_cfg_if.sink   cfg_ch
);

  btgb_pkg::dp_cmd_t    cmd;
  btgb_pkg::dp_status_t sts;

  // register writes are always taken
  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = cmd.in_ready;

  btgb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .sts      (sts),
    .cmd      (cmd)
  );

  btgb_dpath #(
    .FONT_GLYPHS (FONT_GLYPHS),
    .GLYPH_ROWS  (GLYPH_ROWS)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .cfg_we      (cfg_ch.valid),
    .cfg_index   (cfg_ch.index),
    .cfg_data    (cfg_ch.data),
    .in_cmd      (in_ch.cmd),
    .new_string  (in_ch.new_string),
    .origin_x    (in_ch.origin_x),
    .origin_y    (in_ch.origin_y),
    .char_code   (in_ch.char_code),
    .draw_color  (in_ch.draw_color),
    .font_index  (in_ch.font_index),
    .font_byte   (in_ch.font_byte),
    .out_ready   (out_ch.ready),
    .out_valid   (out_ch.valid),
    .row_address (out_ch.row_address),
    .pixel_mask  (out_ch.pixel_mask),
    .pixel_color (out_ch.pixel_color),
    .last_row    (out_ch.last_row)
  );

endmodule

/* src/btgb_checker.sv */
`include "bitmap_text_glyph_blitter_defines.svh"

module btgb_checker (
  input logic         clk,
  input logic         rst,
  btgb_in_if.sink     in_ch,
  btgb_out_if.source  out_ch,
  btgb_cfg_if.sink    cfg_ch
);

  // a stalled row write holds its payload
  `BTGB_ASSERT_NEXT(a_out_hold, clk, rst, out_ch.valid && !out_ch.ready, out_ch.valid && $stable(out_ch.row_address) && $stable(out_ch.pixel_mask) && $stable(out_ch.last_row))

  // no new character is taken while rows of the current glyph remain
  `BTGB_ASSERT_NOW(a_busy_rows, clk, rst, out_ch.valid && !out_ch.last_row, !in_ch.ready)

  // rows of one glyph follow without a gap and share the colour
  `BTGB_ASSERT_NEXT(a_row_follow, clk, rst, out_ch.valid && out_ch.ready && !out_ch.last_row, out_ch.valid && (out_ch.pixel_color == $past(out_ch.pixel_color)))

  // register writes never stall
  `BTGB_ASSERT_NOW(a_cfg_ready, clk, rst, cfg_ch.valid, cfg_ch.ready)

endmodule

bind bitmap_text_glyph_blitter btgb_checker u_btgb_checker (
  .clk    (clk),
  .rst    (rst),
  .in_ch  (in_ch),
  .out_ch (out_ch),
  .cfg_ch (cfg_ch)
);

/* tb/sv/tb_bitmap_text_glyph_blitter.sv */
module tb_bitmap_text_glyph_blitter;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int GLYPH_ROWS  = 16;
  localparam int FONT_BYTES  = 256 * 16;
  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE      = GLYPH_ROWS + 8;
  localparam int RAND_PHASES = 6;
  localparam int PHASE_CHARS = 26;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_DRAW = 1'b1;

  // small set of printable glyphs keeps the font loading short
  localparam logic [btgb_pkg::CODE_W-1:0] GLYPH_POOL [4] = '{8'h01, 8'h41, 8'h80, 8'hFF};

  typedef struct {
    logic                           cmd;
    logic                           new_string;
    logic [btgb_pkg::COORD_W-1:0]   origin_x;
    logic [btgb_pkg::COORD_W-1:0]   origin_y;
    logic [btgb_pkg::CODE_W-1:0]    char_code;
    logic [btgb_pkg::COLOR_W-1:0]   draw_color;
    logic [btgb_pkg::FIDX_W-1:0]    font_index;
    logic [btgb_pkg::FBYTE_W-1:0]   font_byte;
  } char_cmd_t;

  typedef struct {
    logic [btgb_pkg::ADDR_W-1:0]  row_address;
    logic [btgb_pkg::MASK_W-1:0]  pixel_mask;
    logic [btgb_pkg::COLOR_W-1:0] pixel_color;
    logic                         last_row;
  } row_write_t;

  logic clk;
  logic rst;

  btgb_in_if  in_ch();
  btgb_out_if out_ch();
  btgb_cfg_if cfg_ch();

  bitmap_text_glyph_blitter uut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // frame registers, shared by stimulus and prediction (changed only while idle)
  logic [btgb_pkg::ADDR_W-1:0]   frame_base;
  logic [btgb_pkg::DIM_W-1:0]    frame_w;
  logic [btgb_pkg::DIM_W-1:0]    frame_h;
  logic [btgb_pkg::STRIDE_W-1:0] row_stride;

  // predicted text state
  logic [btgb_pkg::COORD_W-1:0] cur_x;
  logic [btgb_pkg::COORD_W-1:0] cur_y;
  logic [btgb_pkg::COORD_W-1:0] line_x;
  logic                         halted;
  logic [btgb_pkg::FBYTE_W-1:0] font_rom [0:FONT_BYTES-1];

  char_cmd_t  char_stream_q[$];
  row_write_t pending_rows[$];
  bit         glyph_ready [0:255];

  char_cmd_t next_char;
  row_write_t got_row;
  row_write_t want_row;
  int  send_gap;
  int  stall_left;
  bit  idle_on;
  int  fail_count;
  int  cycle_count;

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic logic [btgb_pkg::COORD_W-1:0] step_coord(
    input logic [btgb_pkg::COORD_W-1:0] v,
    input int unsigned d
  );
    int unsigned s;
    s = v + d;
    return (s > btgb_pkg::COORD_MAX) ? btgb_pkg::COORD_MAX : btgb_pkg::COORD_W'(s);
  endfunction

  // expected row writes and font updates for one accepted transaction
  function automatic void render_char(input char_cmd_t t);
    int unsigned cols;
    int unsigned rows;
    logic [btgb_pkg::MASK_W-1:0] clip;
    row_write_t w;
    if (t.cmd == CMD_LOAD) begin
      font_rom[t.font_index] = t.font_byte;
      return;
    end
    if (t.new_string) begin
      cur_x  = t.origin_x;
      cur_y  = t.origin_y;
      line_x = t.origin_x;
      halted = 1'b0;
    end
    if (halted) return;
    case (t.char_code)
      btgb_pkg::CHAR_NUL: halted = 1'b1;
      btgb_pkg::CHAR_CR: cur_x = line_x;
      btgb_pkg::CHAR_LF: begin
        cur_x = line_x;
        cur_y = step_coord(cur_y, btgb_pkg::LINE_STEP);
      end
      default: begin
        if (frame_w >= btgb_pkg::GLYPH_W && cur_x < frame_w && cur_y < frame_h) begin
          cols = frame_w - cur_x;
          if (cols > btgb_pkg::GLYPH_W) cols = btgb_pkg::GLYPH_W;
          rows = frame_h - cur_y;
          if (rows > GLYPH_ROWS) rows = GLYPH_ROWS;
          clip = 8'hFF << (btgb_pkg::GLYPH_W - cols);
          for (int i = 0; i < rows; i++) begin
            w.row_address = frame_base + btgb_pkg::ADDR_W'(cur_x)
                            + (btgb_pkg::ADDR_W'(cur_y) + btgb_pkg::ADDR_W'(i))
                            * btgb_pkg::ADDR_W'(row_stride);
            w.pixel_mask  = font_rom[{t.char_code, 4'(i)}] & clip;
            w.pixel_color = t.draw_color;
            w.last_row    = (i + 1 == rows);
            pending_rows.push_back(w);
          end
        end
        cur_x = step_coord(cur_x, btgb_pkg::GLYPH_W);
      end
    endcase
  endfunction

  // random character: control codes or a glyph from the pool
  function automatic logic [btgb_pkg::CODE_W-1:0] pick_code();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 4) return btgb_pkg::CHAR_NUL;
    if (pick < 9) return btgb_pkg::CHAR_CR;
    if (pick < 16) return btgb_pkg::CHAR_LF;
    return GLYPH_POOL[$urandom_range(0, 3)];
  endfunction

  // input driver
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      send_gap = 0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (send_gap > 0) begin
        in_ch.valid <= 1'b0;
        send_gap--;
      end else if (char_stream_q.size() != 0) begin
        next_char = char_stream_q.pop_front();
        in_ch.valid      <= 1'b1;
        in_ch.cmd        <= next_char.cmd;
        in_ch.new_string <= next_char.new_string;
        in_ch.origin_x   <= next_char.origin_x;
        in_ch.origin_y   <= next_char.origin_y;
        in_ch.char_code  <= next_char.char_code;
        in_ch.draw_color <= next_char.draw_color;
        in_ch.font_index <= next_char.font_index;
        in_ch.font_byte  <= next_char.font_byte;
        if (idle_on && $urandom_range(0, 4) == 0) send_gap = $urandom_range(1, 6);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // input monitor feeds the predictor
  always @(posedge clk) begin
    if (!rst && in_ch.valid && in_ch.ready) begin
      render_char(char_cmd_t'{in_ch.cmd, in_ch.new_string, in_ch.origin_x,
                              in_ch.origin_y, in_ch.char_code, in_ch.draw_color,
                              in_ch.font_index, in_ch.font_byte});
    end
  end

  // output ready with random stall bursts
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left--;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      out_ch.ready <= 1'b0;
      stall_left = $urandom_range(0, 5);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // output monitor and compare
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      got_row = row_write_t'{out_ch.row_address, out_ch.pixel_mask, out_ch.pixel_color,
                             out_ch.last_row};
      if (pending_rows.size() == 0) begin
        $error("unexpected row write: row_address %h pixel_mask %h",
               got_row.row_address, got_row.pixel_mask);
        fail_count++;
      end else begin
        want_row = pending_rows.pop_front();
        if (got_row.row_address !== want_row.row_address) begin
          $error("row_address expected %h actual %h", want_row.row_address,
                 got_row.row_address);
          fail_count++;
        end
        if (got_row.pixel_mask !== want_row.pixel_mask) begin
          $error("pixel_mask expected %h actual %h", want_row.pixel_mask,
                 got_row.pixel_mask);
          fail_count++;
        end
        if (got_row.pixel_color !== want_row.pixel_color) begin
          $error("pixel_color expected %h actual %h", want_row.pixel_color,
                 got_row.pixel_color);
          fail_count++;
        end
        if (got_row.last_row !== want_row.last_row) begin
          $error("last_row expected %b actual %b", want_row.last_row,
                 got_row.last_row);
          fail_count++;
        end
      end
    end
  end

  // run limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

  task automatic write_reg(input btgb_pkg::cfg_reg_t idx,
                           input logic [btgb_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic set_frame(input logic [btgb_pkg::ADDR_W-1:0] base,
                           input logic [btgb_pkg::DIM_W-1:0] w,
                           input logic [btgb_pkg::DIM_W-1:0] h,
                           input logic [btgb_pkg::STRIDE_W-1:0] stride);
    write_reg(btgb_pkg::REG_FRAME_BASE, base);
    write_reg(btgb_pkg::REG_FRAME_WIDTH, btgb_pkg::CFG_DATA_W'(w));
    write_reg(btgb_pkg::REG_FRAME_HEIGHT, btgb_pkg::CFG_DATA_W'(h));
    write_reg(btgb_pkg::REG_ROW_STRIDE, btgb_pkg::CFG_DATA_W'(stride));
    frame_base = base;
    frame_w    = w;
    frame_h    = h;
    row_stride = stride;
  endtask

  // font load with random junk in the unused fields
  task automatic push_load(input logic [btgb_pkg::FIDX_W-1:0] idx,
                           input logic [btgb_pkg::FBYTE_W-1:0] bits);
    char_stream_q.push_back(char_cmd_t'{CMD_LOAD, 1'($urandom), 16'($urandom),
                                        16'($urandom), 8'($urandom), $urandom, idx, bits});
  endtask

  task automatic load_glyph(input logic [btgb_pkg::CODE_W-1:0] code);
    for (int r = 0; r < GLYPH_ROWS; r++) push_load({code, 4'(r)}, 8'($urandom));
    glyph_ready[code] = 1'b1;
  endtask

  // a draw never reads a glyph that has not been loaded
  task automatic push_draw(input logic ns, input logic [btgb_pkg::COORD_W-1:0] ox,
                           input logic [btgb_pkg::COORD_W-1:0] oy,
                           input logic [btgb_pkg::CODE_W-1:0] code,
                           input logic [btgb_pkg::COLOR_W-1:0] color);
    if (code != btgb_pkg::CHAR_NUL && code != btgb_pkg::CHAR_CR
        && code != btgb_pkg::CHAR_LF && !glyph_ready[code])
      load_glyph(code);
    char_stream_q.push_back(char_cmd_t'{CMD_DRAW, ns, ox, oy, code, color, 12'($urandom),
                                        8'($urandom)});
  endtask

  // wait for the block to go quiet
  task automatic drain();
    while (char_stream_q.size() != 0 || in_ch.valid || pending_rows.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic random_phase(input int n_chars);
    logic [btgb_pkg::DIM_W-1:0]    w;
    logic [btgb_pkg::DIM_W-1:0]    h;
    logic [btgb_pkg::STRIDE_W-1:0] stride;
    logic                          in_text;
    logic [btgb_pkg::CODE_W-1:0]   code;
    int                            r;
    case ($urandom_range(0, 9))
      0: w = $urandom_range(0, 7);
      1: w = 4096;
      default: w = $urandom_range(8, 300);
    endcase
    case ($urandom_range(0, 9))
      0: h = $urandom_range(0, 15);
      1: h = 4096;
      default: h = $urandom_range(16, 300);
    endcase
    stride = ($urandom_range(0, 3) == 0) ? 14'($urandom_range(0, 8192)) : 14'(w);
    set_frame($urandom, w, h, stride);
    in_text = 1'b0;
    for (int k = 0; k < n_chars; k++) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        push_load(12'($urandom), 8'($urandom));
      end else if (r < 12) begin
        // noise: any origin and any string flag
        push_draw(1'($urandom), 16'($urandom), 16'($urandom), pick_code(), $urandom);
      end else begin
        code = pick_code();
        if (!in_text || r < 18) begin
          push_draw(1'b1, 16'($urandom_range(0, w + 4)), 16'($urandom_range(0, h + 4)),
                    code, $urandom);
          in_text = 1'b1;
        end else begin
          push_draw(1'b0, 16'($urandom), 16'($urandom), code, $urandom);
        end
        if (code == btgb_pkg::CHAR_NUL) in_text = 1'b0;
      end
    end
    drain();
  endtask

  // stimulus
  initial begin
    rst               = 1'b1;
    in_ch.valid       = 1'b0;
    in_ch.cmd         = CMD_LOAD;
    in_ch.new_string  = 1'b0;
    in_ch.origin_x    = '0;
    in_ch.origin_y    = '0;
    in_ch.char_code   = btgb_pkg::CHAR_NUL;
    in_ch.draw_color  = '0;
    in_ch.font_index  = '0;
    in_ch.font_byte   = '0;
    out_ch.ready      = 1'b0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = btgb_pkg::REG_FRAME_BASE;
    cfg_ch.data       = '0;
    frame_base        = '0;
    frame_w           = btgb_pkg::RST_FRAME_WIDTH;
    frame_h           = btgb_pkg::RST_FRAME_HEIGHT;
    row_stride        = btgb_pkg::RST_ROW_STRIDE;
    cur_x             = '0;
    cur_y             = '0;
    line_x            = '0;
    halted            = 1'b1;
    idle_on           = 1'b1;
    fail_count        = 0;
    foreach (glyph_ready[g]) glyph_ready[g] = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset frame settings: stop state, control characters, clipping, saturation
    load_glyph(8'h01);
    load_glyph(8'hFF);
    push_load(12'h010, 8'hFF);
    push_load(12'hFFF, 8'h81);
    push_load(12'h000, 8'h00);
    push_draw(1'b0, 16'd0, 16'd0, 8'h01, 32'h1234_5678);
    push_draw(1'b1, 16'd0, 16'd0, 8'h01, 32'hFFFF_FFFF);
    push_draw(1'b0, 16'd0, 16'd0, 8'hFF, 32'h0000_0000);
    push_draw(1'b0, 16'd0, 16'd0, btgb_pkg::CHAR_CR, $urandom);
    push_draw(1'b0, 16'd0, 16'd0, 8'h01, 32'hA5A5_5A5A);
    push_draw(1'b0, 16'd0, 16'd0, btgb_pkg::CHAR_LF, $urandom);
    push_draw(1'b0, 16'd0, 16'd0, 8'hFF, 32'h0F0F_F0F0);
    push_draw(1'b0, 16'd0, 16'd0, btgb_pkg::CHAR_NUL, $urandom);
    push_draw(1'b0, 16'd0, 16'd0, 8'h01, $urandom);
    push_draw(1'b1, 16'd636, 16'd470, 8'hFF, 32'hCAFE_0001);
    push_draw(1'b0, 16'd0, 16'd0, 8'h01, 32'hCAFE_0002);
    push_draw(1'b1, 16'hFFFC, 16'hFFF8, 8'h01, $urandom);
    push_draw(1'b0, 16'd0, 16'd0, 8'h01, $urandom);
    push_draw(1'b0, 16'd0, 16'd0, btgb_pkg::CHAR_LF, $urandom);
    push_draw(1'b1, 16'd100, 16'd479, 8'h01, 32'h0000_FFFF);
    drain();

    // 4096 by 4096 frame with address wrap
    set_frame(32'hFFFF_FFF8, 13'd4096, 13'd4096, 14'd8192);
    push_draw(1'b1, 16'd4090, 16'd4094, 8'hFF, 32'h1111_2222);
    push_draw(1'b1, 16'd0, 16'd0, 8'h01, 32'h3333_4444);
    drain();

    // frame too narrow to draw
    set_frame(32'h0000_0000, 13'd7, 13'd4096, 14'd0);
    push_draw(1'b1, 16'd0, 16'd0, 8'h01, $urandom);
    push_draw(1'b0, 16'd0, 16'd0, 8'hFF, $urandom);
    drain();

    // empty frame
    set_frame(32'h8000_0000, 13'd0, 13'd0, 14'd1);
    push_draw(1'b1, 16'd0, 16'd0, 8'h01, $urandom);
    drain();

    // single-row frame, exactly one glyph wide
    set_frame(32'h0000_0100, 13'd8, 13'd1, 14'd8192);
    push_draw(1'b1, 16'd0, 16'd0, 8'hFF, 32'h7777_8888);
    push_draw(1'b0, 16'd0, 16'd0, 8'h01, $urandom);
    drain();

    // random phases, the last one without idling
    for (int p = 0; p < RAND_PHASES; p++) begin
      idle_on = (p == RAND_PHASES - 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
      random_phase(PHASE_CHARS);
    end

    if (pending_rows.size() != 0) begin
      $error("%0d row writes never arrived", pending_rows.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
